// File: design/lcd_text_block_writer_assert.svh
// Assertion macros for the LCD text block writer checker.
// Included by the checker file only; no other dependencies.
`ifndef LCD_TEXT_BLOCK_WRITER_ASSERT_SVH
`define LCD_TEXT_BLOCK_WRITER_ASSERT_SVH

// Checked property, ignored while reset is high
`define LTBW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ltbw assertion failed");

// Checked property, evaluated during reset as well
`define LTBW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ltbw assertion failed");

`endif

// File: design/ltbw_pkg.sv
// Shared types, codes and constants for the LCD text block writer.
// No dependencies; imported by every module of the block but the checker.
`timescale 1ns / 1ps

package ltbw_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_CMD   = 2'd2,
    MODE_DATA  = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_BACKLIGHT = 2'd2;

  localparam logic [4:0] COLUMNS_RESET   = 5'd16;
  localparam logic [2:0] ROWS_RESET      = 3'd2;
  localparam logic       BACKLIGHT_RESET = 1'b1;
  localparam logic [2:0] MAX_ROWS        = 3'd4;

  // Display RAM distance between rows 0 and 2
  localparam int ROW_PITCH = 20;
  localparam logic [7:0] ROW_ADJ = 8'(256 - ROW_PITCH);

  localparam logic [7:0] EN_BIT = 8'h04;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [4:0] columns;
    logic [2:0] rows_in_use;
    logic       backlight_on;
  } ltbw_cfg_t;

  // One classified request: one or two bytes to send
  typedef struct packed {
    logic [7:0] byte0;
    logic       rs0;
    logic [7:0] byte1;   // always a data write
    logic       two;
  } ltbw_entry_t;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

endpackage

// File: design/ltbw_front.sv
// Front end: accepts input requests, tracks the block cursor and classifies.
// Depends on ltbw_pkg; feeds ltbw_queue.
`timescale 1ns / 1ps

module ltbw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  input  ltbw_pkg::ltbw_cfg_t cfg,
  input  logic               queue_full,
  output logic               push,
  output ltbw_pkg::ltbw_entry_t entry
);
  import ltbw_pkg::*;

  logic [4:0] cursor_col, cursor_col_next;
  logic [2:0] cursor_row, cursor_row_next;
  logic       block_full, block_full_next;

  logic       accept;
  mode_t      mode;
  logic [7:0] value;
  logic [4:0] start_col;
  logic [1:0] start_row;
  logic [2:0] eff_rows;
  logic       outside;
  logic [4:0] col_inc;
  logic [7:0] addr;

  assign s_tready  = !queue_full;
  assign accept    = s_tvalid && s_tready;
  assign mode      = mode_t'(s_tuser);
  assign value     = s_tdata[7:0];
  assign start_col = s_tdata[12:8];
  assign start_row = s_tdata[14:13];

  // Position checks and set-address command
  always_comb begin
    eff_rows = (cfg.rows_in_use > MAX_ROWS) ? MAX_ROWS : cfg.rows_in_use;
    outside  = block_full || (cursor_col >= cfg.columns) || (cursor_row >= eff_rows);
    col_inc  = cursor_col + 5'd1;
    addr     = row_base(cursor_row[1:0]) + {3'b000, cursor_col};
    if (cursor_row >= 3'd2) begin
      addr = addr + {3'b000, cfg.columns} + ROW_ADJ;
    end
  end

  // Classification and cursor update
  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    block_full_next = block_full;
    push            = 1'b0;
    entry.byte0     = value;
    entry.rs0       = 1'b0;
    entry.byte1     = value;
    entry.two       = 1'b0;
    if (accept) begin
      unique case (mode)
        MODE_START: begin
          cursor_col_next = start_col;
          cursor_row_next = {1'b0, start_row};
          block_full_next = (start_col >= cfg.columns) || ({1'b0, start_row} >= eff_rows);
        end
        MODE_CHAR: begin
          if (outside) begin
            block_full_next = 1'b1;
          end else begin
            push        = 1'b1;
            entry.byte0 = addr;
            entry.two   = 1'b1;
            if (col_inc >= cfg.columns) begin
              cursor_col_next = '0;
              cursor_row_next = cursor_row + 3'd1;
              if ((cursor_row + 3'd1) >= eff_rows) begin
                block_full_next = 1'b1;
              end
            end else begin
              cursor_col_next = col_inc;
            end
          end
        end
        MODE_CMD: begin
          push = 1'b1;
        end
        MODE_DATA: begin
          push      = 1'b1;
          entry.rs0 = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      block_full <= 1'b0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      block_full <= block_full_next;
    end
  end

endmodule

// File: design/ltbw_queue.sv
// Short request queue between the front end and the write sequencer.
// Depends on ltbw_pkg for the entry type.
`timescale 1ns / 1ps

module ltbw_queue #(
  parameter int DEPTH = ltbw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ltbw_pkg::ltbw_entry_t push_entry,
  input  logic                  pop,
  output ltbw_pkg::ltbw_entry_t head,
  output logic                  empty,
  output logic                  full
);
  import ltbw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ltbw_entry_t    slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/ltbw_back.sv
// Write sequencer: turns queued bytes into 4-bit expander writes.
// Depends on ltbw_pkg; drains ltbw_queue into the output register.
`timescale 1ns / 1ps

module ltbw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ltbw_pkg::ltbw_cfg_t   cfg,
  input  ltbw_pkg::ltbw_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast
);
  import ltbw_pkg::*;

  // step[3] byte, step[2] nibble, step[1:0] strobe phase
  logic [3:0] step;
  logic       advance;
  logic [7:0] cur_byte;
  logic       rs;
  logic [7:0] nib;
  logic [7:0] bl;
  logic [7:0] wr_byte;
  logic       wr_last;

  assign advance = !empty && (!m_tvalid || m_tready);

  always_comb begin
    cur_byte = step[3] ? head.byte1 : head.byte0;
    rs       = step[3] ? 1'b1 : head.rs0;
    nib      = step[2] ? {cur_byte[3:0], 4'h0} : {cur_byte[7:4], 4'h0};
    bl       = {4'h0, cfg.backlight_on, 3'b000};
    unique case (step[1:0])
      2'd1:    wr_byte = {7'd0, rs} | EN_BIT | bl;
      2'd2:    wr_byte = {7'd0, rs} | nib | EN_BIT | bl;
      default: wr_byte = {7'd0, rs} | bl;
    endcase
    wr_last = (step == {head.two, 3'b111});
    pop     = advance && wr_last;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (advance) begin
      step <= wr_last ? 4'd0 : step + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= wr_byte;
      m_tlast <= wr_last;
    end
  end

endmodule

// File: design/lcd_text_block_writer.sv
// Top level of the LCD text block writer: config registers and wiring.
// Depends on ltbw_pkg, ltbw_front, ltbw_queue and ltbw_back.
//
// Use: requests enter on the s_ channel (tuser = kind, tdata = text or
// position), expander writes leave on the m_ channel, one byte per write,
// tlast marking the final write of each request. A start request sets the
// row and column of a text block and sends nothing. A block character sends
// a set-address command and a data write: 16 writes. Raw command and raw
// data requests send 8 writes. Dropped characters send nothing.
// A taken request is written into the request queue, and its first write
// then leaves through the output register. Throughput: one write per
// cycle from the sequencer while m_tready is high; the write sequencer
// sets this rate. The front end takes a new request whenever the request
// queue has room. Stalls: when m_tready is low the output register holds;
// the queue fills and then s_tready falls. Reset clears the cursor, the
// queue and the output, and loads 16 columns, 2 rows, backlight on.
// Configuration: write cfg_data to cfg_index while the block is idle.
`timescale 1ns / 1ps

module lcd_text_block_writer #(
  parameter int QUEUE_DEPTH = ltbw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value[7:0], start_col[12:8], start_row[14:13], zero
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // expander_byte[7:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import ltbw_pkg::*;

  ltbw_cfg_t   cfg;
  ltbw_entry_t push_entry;
  ltbw_entry_t head;
  logic        push, pop, empty, full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns      <= COLUMNS_RESET;
      cfg.rows_in_use  <= ROWS_RESET;
      cfg.backlight_on <= BACKLIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS:   cfg.columns      <= cfg_data;
        REG_ROWS:      cfg.rows_in_use  <= cfg_data[2:0];
        REG_BACKLIGHT: cfg.backlight_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ltbw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg        (cfg),
    .queue_full (full),
    .push       (push),
    .entry      (push_entry)
  );

  ltbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  ltbw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/ltbw_checker.sv
// Port-level checks for the LCD text block writer, bound to the top level.
// Depends on lcd_text_block_writer_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "lcd_text_block_writer_assert.svh"

module ltbw_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic out_stall;

  assign out_stall = m_tvalid && !m_tready;

  // A stalled write holds its byte and marker
  `LTBW_ASSERT(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Expander bit 1 is never driven
  `LTBW_ASSERT(a_bit1_low, clk, rst, m_tvalid |-> !m_tdata[1])

  // Each request ends on a strobe-low write with an empty nibble
  `LTBW_ASSERT(a_last_idle, clk, rst, m_tvalid && m_tlast |-> !m_tdata[2] && m_tdata[7:4] == 4'h0)

  // Nothing is offered right after reset
  `LTBW_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_tvalid)

endmodule

bind lcd_text_block_writer ltbw_checker u_ltbw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
